>>> rtl/core/ablp_pkg.sv
package ablp_pkg;

    // Protocol constants
    localparam logic [7:0] MAGIC_BYTE   = 8'hAB;
    localparam logic [8:0] HDR_OVERHEAD = 9'd6;   // 4 byte header + 2 byte checksum
    localparam logic [1:0] POST_TRIES   = 2'd3;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 8;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_LINK_MODE   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD = 8'd1;

    localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd60;

    typedef enum logic [1:0] {
        CMD_SEND = 2'd0,
        CMD_RX   = 2'd1,
        CMD_POST = 2'd2,
        CMD_TAKE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_PASSIVE = 2'd1,
        MODE_ACTIVE  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        WAKE_EVENT = 2'd0,
        WAKE_SHORT = 2'd1,
        WAKE_LONG  = 2'd2
    } wake_t;

    typedef enum logic [1:0] {
        ST_HANDLED  = 2'd0,
        ST_IGNORED  = 2'd1,
        ST_REJECTED = 2'd2
    } status_t;

    typedef struct packed {
        mode_t      link_mode;
        logic [7:0] max_payload;
    } cfg_t;

    typedef struct packed {
        cmd_t       cmd;
        logic       tx_room;
        logic [7:0] rx_magic;
        logic [7:0] rx_seq_sent;
        logic [7:0] rx_seq_wanted;
        logic [7:0] rx_payload_len;
        logic [8:0] rx_total_len;
        logic [7:0] post_len;
    } item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_seq_sent;
        logic [7:0] tx_seq_wanted;
        logic [7:0] tx_payload_len;
        logic [8:0] tx_total_len;
        wake_t      wake_code;
        logic       outgoing_done;
        logic       incoming_delivered;
        logic [7:0] incoming_len;
        status_t    status;
    } result_t;

endpackage

>>> rtl/core/ablp_ifs.sv
interface ablp_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic       tx_room;
    logic [7:0] rx_magic;
    logic [7:0] rx_seq_sent;
    logic [7:0] rx_seq_wanted;
    logic [7:0] rx_payload_len;
    logic [8:0] rx_total_len;
    logic [7:0] post_len;

    modport source (
        output valid, cmd, tx_room, rx_magic, rx_seq_sent, rx_seq_wanted,
               rx_payload_len, rx_total_len, post_len,
        input  ready
    );
    modport sink (
        input  valid, cmd, tx_room, rx_magic, rx_seq_sent, rx_seq_wanted,
               rx_payload_len, rx_total_len, post_len,
        output ready
    );
endinterface

interface ablp_rsp_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_seq_sent;
    logic [7:0] tx_seq_wanted;
    logic [7:0] tx_payload_len;
    logic [8:0] tx_total_len;
    logic [1:0] wake_code;
    logic       outgoing_done;
    logic       incoming_delivered;
    logic [7:0] incoming_len;
    logic [1:0] status;

    modport source (
        output valid, tx_valid, tx_seq_sent, tx_seq_wanted, tx_payload_len,
               tx_total_len, wake_code, outgoing_done, incoming_delivered,
               incoming_len, status,
        input  ready
    );
    modport sink (
        input  valid, tx_valid, tx_seq_sent, tx_seq_wanted, tx_payload_len,
               tx_total_len, wake_code, outgoing_done, incoming_delivered,
               incoming_len, status,
        output ready
    );
endinterface

interface ablp_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

>>> rtl/core/alternating_bit_link_protocol.sv
// Alternating-bit link engine: control side of a sequence-numbered
// acknowledge protocol on a serial link.
//
// Channels (valid/ready, a word moves when both are high):
//   req - one event word: send opportunity, received header, host post
//         or host take, with the header fields and the post length.
//   rsp - one result word per event: header to transmit, wake code,
//         acknowledge / delivery flags, incoming length and status.
//   cfg - register writes (0 link_mode, 1 max_payload); always ready.
//         Write only while the engine is idle.
// Timing: an accepted event lands in the input register; the decision logic
// then runs against the protocol state and the result word is captured in
// the output register, from which it is offered on rsp. One event per cycle
// is sustained while rsp takes each word; the single input->output register
// pair per event sets that figure.
// Stall: if rsp is held off, the output register keeps its word, the input
// register holds one more event, then req.ready drops until rsp drains.
// Reset: state cleared, link_mode passive, max_payload 60, no words held.
module alternating_bit_link_protocol (
    input  logic      clk,
    input  logic      rst_n,
    ablp_cfg_if.sink  cfg,
    ablp_req_if.sink  req,
    ablp_rsp_if.source rsp
);
    import ablp_pkg::*;

    cfg_t    cfg_cur;
    item_t   item_in;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t result;
    result_t rsp_reg;
    logic    rsp_valid_reg;
    logic    advance;
    logic    req_fire;

    // input side word
    assign item_in.cmd            = cmd_t'(req.cmd);
    assign item_in.tx_room        = req.tx_room;
    assign item_in.rx_magic       = req.rx_magic;
    assign item_in.rx_seq_sent    = req.rx_seq_sent;
    assign item_in.rx_seq_wanted  = req.rx_seq_wanted;
    assign item_in.rx_payload_len = req.rx_payload_len;
    assign item_in.rx_total_len   = req.rx_total_len;
    assign item_in.post_len       = req.post_len;

    // event moves into the output register when that register is empty or its word is being taken
    assign advance   = item_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !item_valid_reg || advance;
    assign req_fire  = req.valid && req.ready;

    ablp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_cur)
    );

    ablp_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg_cur),
        .result  (result)
    );

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req.ready)
                item_valid_reg <= req.valid;
            if (advance)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (req_fire)
            item_reg <= item_in;
        if (advance)
            rsp_reg <= result;
    end

    assign rsp.valid              = rsp_valid_reg;
    assign rsp.tx_valid           = rsp_reg.tx_valid;
    assign rsp.tx_seq_sent        = rsp_reg.tx_seq_sent;
    assign rsp.tx_seq_wanted      = rsp_reg.tx_seq_wanted;
    assign rsp.tx_payload_len     = rsp_reg.tx_payload_len;
    assign rsp.tx_total_len       = rsp_reg.tx_total_len;
    assign rsp.wake_code          = rsp_reg.wake_code;
    assign rsp.outgoing_done      = rsp_reg.outgoing_done;
    assign rsp.incoming_delivered = rsp_reg.incoming_delivered;
    assign rsp.incoming_len       = rsp_reg.incoming_len;
    assign rsp.status             = rsp_reg.status;

endmodule

>>> rtl/core/ablp_cfg_regs.sv
module ablp_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    ablp_cfg_if.sink      cfg,
    output ablp_pkg::cfg_t cfg_out
);
    import ablp_pkg::*;

    mode_t      link_mode_reg, link_mode_next;
    logic [7:0] max_payload_reg, max_payload_next;
    logic       wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid;

    always_comb
    begin
        link_mode_next   = link_mode_reg;
        max_payload_next = max_payload_reg;
        if (wr_en)
        begin
            unique case (cfg.index)
                REG_LINK_MODE:
                begin
                    // code 3 is unused and folds to active
                    if (cfg.data[1:0] == 2'd3)
                        link_mode_next = MODE_ACTIVE;
                    else
                        link_mode_next = mode_t'(cfg.data[1:0]);
                end
                REG_MAX_PAYLOAD:
                    max_payload_next = cfg.data;
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_mode_reg   <= MODE_PASSIVE;
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else
        begin
            link_mode_reg   <= link_mode_next;
            max_payload_reg <= max_payload_next;
        end
    end

    assign cfg_out.link_mode   = link_mode_reg;
    assign cfg_out.max_payload = max_payload_reg;

endmodule

>>> rtl/core/ablp_engine.sv
module ablp_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  ablp_pkg::item_t  item,
    input  ablp_pkg::cfg_t   cfg,
    output ablp_pkg::result_t result
);
    import ablp_pkg::*;

    logic [7:0] seq_current_reg, seq_current_next;
    logic [7:0] seq_expected_reg, seq_expected_next;
    logic [1:0] retries_left_reg, retries_left_next;
    logic       outgoing_held_reg, outgoing_held_next;
    logic [7:0] outgoing_len_reg, outgoing_len_next;
    logic       incoming_held_reg, incoming_held_next;
    logic [7:0] incoming_len_held_reg, incoming_len_held_next;

    logic       attempt;
    logic [7:0] send_len;
    logic [1:0] retries_dec;
    logic [8:0] rx_room;
    logic [1:0] rl;

    always_comb
    begin
        seq_current_next       = seq_current_reg;
        seq_expected_next      = seq_expected_reg;
        retries_left_next      = retries_left_reg;
        outgoing_held_next     = outgoing_held_reg;
        outgoing_len_next      = outgoing_len_reg;
        incoming_held_next     = incoming_held_reg;
        incoming_len_held_next = incoming_len_held_reg;
        result                 = '0;
        result.wake_code       = WAKE_EVENT;
        result.status          = ST_HANDLED;

        attempt     = 1'b0;
        send_len    = 8'd0;
        retries_dec = retries_left_reg - 2'd1;
        rx_room     = item.rx_total_len - HDR_OVERHEAD;
        rl          = retries_left_reg;

        unique case (item.cmd)
            CMD_SEND:
            begin
                case (cfg.link_mode)
                    MODE_PASSIVE: attempt = (retries_left_reg != 2'd0);
                    MODE_ACTIVE:  attempt = 1'b1;
                    default:      attempt = 1'b0;
                endcase
                if (outgoing_held_reg)
                    send_len = (outgoing_len_reg > cfg.max_payload) ?
                               cfg.max_payload : outgoing_len_reg;
                if (attempt)
                begin
                    if (item.tx_room)
                    begin
                        result.tx_valid       = 1'b1;
                        result.tx_seq_sent    = seq_current_reg;
                        result.tx_seq_wanted  = seq_expected_reg;
                        result.tx_payload_len = send_len;
                        // pad to even length
                        result.tx_total_len   = {1'b0, send_len} + HDR_OVERHEAD
                                                + {8'd0, send_len[0]};
                    end
                    if (cfg.link_mode == MODE_PASSIVE)
                    begin
                        if (item.tx_room)
                        begin
                            retries_left_next = retries_dec;
                            result.wake_code  = (retries_dec != 2'd0) ?
                                                WAKE_LONG : WAKE_EVENT;
                        end
                        else
                            result.wake_code = WAKE_SHORT;
                    end
                    else
                    begin
                        result.wake_code = item.tx_room ? WAKE_LONG : WAKE_SHORT;
                        if (retries_left_reg != 2'd0)
                            retries_left_next = retries_dec;
                    end
                end
            end
            CMD_RX:
            begin
                if (item.rx_magic != MAGIC_BYTE)
                    result.status = ST_IGNORED;
                else
                begin
                    if (outgoing_held_reg)
                    begin
                        if (item.rx_seq_wanted != seq_current_reg)
                        begin
                            // partner moved on: outgoing message acknowledged
                            outgoing_held_next   = 1'b0;
                            rl                   = 2'd0;
                            result.outgoing_done = 1'b1;
                            seq_current_next     = item.rx_seq_wanted;
                        end
                        else if (rl == 2'd0)
                            rl = 2'd1;
                    end
                    else
                        seq_current_next = item.rx_seq_wanted;

                    if (item.rx_total_len > HDR_OVERHEAD)
                    begin
                        if (rl == 2'd0)
                            rl = 2'd1;
                        if (item.rx_seq_sent == seq_expected_reg &&
                            item.rx_payload_len != 8'd0 &&
                            {1'b0, item.rx_payload_len} <= rx_room)
                        begin
                            incoming_held_next        = 1'b1;
                            incoming_len_held_next    = item.rx_payload_len;
                            seq_expected_next         = seq_expected_reg + 8'd1;
                            result.incoming_delivered = 1'b1;
                            result.incoming_len       = item.rx_payload_len;
                        end
                    end
                    retries_left_next = rl;
                end
            end
            CMD_POST:
            begin
                if (outgoing_held_reg || cfg.link_mode == MODE_OFF)
                    result.status = ST_REJECTED;
                else
                begin
                    outgoing_held_next = 1'b1;
                    outgoing_len_next  = item.post_len;
                    retries_left_next  = POST_TRIES;
                end
            end
            CMD_TAKE:
            begin
                if (!incoming_held_reg)
                    result.status = ST_REJECTED;
                else
                begin
                    incoming_held_next  = 1'b0;
                    result.incoming_len = incoming_len_held_reg;
                end
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_current_reg       <= 8'd0;
            seq_expected_reg      <= 8'd0;
            retries_left_reg      <= 2'd0;
            outgoing_held_reg     <= 1'b0;
            outgoing_len_reg      <= 8'd0;
            incoming_held_reg     <= 1'b0;
            incoming_len_held_reg <= 8'd0;
        end
        else if (advance)
        begin
            seq_current_reg       <= seq_current_next;
            seq_expected_reg      <= seq_expected_next;
            retries_left_reg      <= retries_left_next;
            outgoing_held_reg     <= outgoing_held_next;
            outgoing_len_reg      <= outgoing_len_next;
            incoming_held_reg     <= incoming_held_next;
            incoming_len_held_reg <= incoming_len_held_next;
        end
    end

endmodule
